// ----- src/assert_macros.svh -----
// assertion macros for the lead delta decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property check, quiet during reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, cond, msg)

`endif

`endif

// ----- src/ecgd_pkg.sv -----
// shared constants for the lead delta decoder
package ecgd_pkg;

    localparam int MAX_SAMPLES = 8192;
    localparam int NUM_LEADS   = 12;

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int CFG_W  = 14;
    localparam int LEAD_W = 4;
    localparam int SNUM_W = 13;
    localparam int SAMP_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [SAMP_W-1:0] LAST_BIAS = 16'd64;
    localparam logic [CFG_W-1:0]  CFG_RESET = 14'd5500;

    localparam logic [LEAD_W-1:0] LEAD_I   = 4'd0;
    localparam logic [LEAD_W-1:0] LEAD_II  = 4'd1;
    localparam logic [LEAD_W-1:0] LEAD_III = 4'd2;
    localparam logic [LEAD_W-1:0] LEAD_AVR = 4'd3;
    localparam logic [LEAD_W-1:0] LEAD_AVL = 4'd4;
    localparam logic [LEAD_W-1:0] LEAD_AVF = 4'd5;

endpackage

// ----- src/ecgd_ram.sv -----
// generic simple dual port ram with registered read
module ecgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/ecg_lead_delta_decoder_unit.sv -----
// top level of the ecg lead delta decoder
//
// input stream carries the expanded bytes of one lead chunk per lead:
// first samples_per_lead high bytes, then as many low bytes. high bytes
// are buffered and produce no output; each low byte yields one sample.
// tuser flags the first byte of a chunk and loads the start value.
// leads i and ii and the rebuilt iii are kept in on-chip ram, so leads
// iii, avr, avl and avf come out already reconstructed.
// throughput: one byte per cycle sustained while the master side does not
// stall. the high plane ram and the lead rams are read on the accept edge,
// which also loads the decode stage, so a sample passes the decode stage
// and then the output register. the sample recurrence closes through one
// decode stage that reads and updates the delta history in the same cycle,
// which sets the byte rate above.
// reset clears byte position, lead count, delta history and the output
// valid; rams are not cleared and hold nothing useful until written.
// a stalled master side holds the output register, then the decode
// stage, and only then drops s_axis ready: no transfer is lost.
// samples_per_lead must be written only while the block is idle; it is not enforced.
module ecg_lead_delta_decoder_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [ecgd_pkg::CFG_W-1:0] cfg_wr_data,   // samples_per_lead
    // byte stream in
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,        // delta_byte[7:0], start_value[23:8]
    input  logic [0:0]                s_tuser,        // chunk_start
    // sample stream out
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,        // sample_value[15:0], sample_number[28:16]
    output logic [3:0]                m_tuser,        // lead_number
    output logic                      m_tlast         // lead_done
);
    import ecgd_pkg::*;

    `include "assert_macros.svh"

    // configuration register
    logic [CFG_W-1:0] cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // effective chunk length, clamped to 1..MAX_SAMPLES
    logic [LEN_W-1:0] len;

    always_comb begin
        if (cfg_reg == '0) begin
            len = LEN_W'(1);
        end else if (32'(cfg_reg) > MAX_SAMPLES) begin
            len = LEN_W'(MAX_SAMPLES);
        end else begin
            len = LEN_W'(cfg_reg);
        end
    end

    // input fields
    logic [BYTE_W-1:0] in_byte;
    logic [SAMP_W-1:0] in_start;
    logic              in_chunk;

    assign in_byte  = s_tdata[7:0];
    assign in_start = s_tdata[23:8];
    assign in_chunk = s_tuser[0];

    // pipeline control
    logic s_xfer;
    logic out_free;
    logic b_adv;
    logic b_valid_reg;
    logic m_valid_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign b_adv    = b_valid_reg && out_free;
    assign s_tready = !b_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;

    // accept side: byte position and lead count
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic [LEN_W-1:0]  pos_chk;
    logic [LEN_W-1:0]  pos_eff;
    logic              is_high;
    logic [LEN_W-1:0]  j_full;
    logic [ADDR_W-1:0] j_addr;
    logic              j_last;

    always_comb begin
        pos_chk = in_chunk ? '0 : pos_reg;
        // length shrank in mid chunk: restart at high byte zero
        if ({1'b0, pos_chk} >= {len, 1'b0}) begin
            pos_eff = '0;
        end else begin
            pos_eff = pos_chk;
        end
        is_high = pos_eff < len;
        j_full  = pos_eff - len;
        j_addr  = j_full[ADDR_W-1:0];
        j_last  = !is_high && (j_full == len - LEN_W'(1));

        pos_next  = pos_reg;
        lead_next = lead_reg;
        if (s_xfer) begin
            if (j_last) begin
                pos_next  = '0;
                lead_next = (lead_reg == LEAD_W'(NUM_LEADS - 1)) ? '0 : lead_reg + LEAD_W'(1);
            end else begin
                pos_next = pos_eff + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            lead_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            lead_reg <= lead_next;
        end
    end

    // high plane buffer: written by high bytes, read by low bytes
    logic [BYTE_W-1:0] high_rd;
    logic              low_xfer;

    assign low_xfer = s_xfer && !is_high;

    ecgd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_SAMPLES)) u_high_plane (
        .aclk    (aclk),
        .wr_en   (s_xfer && is_high),
        .wr_addr (pos_eff[ADDR_W-1:0]),
        .wr_data (in_byte),
        .rd_en   (low_xfer),
        .rd_addr (j_addr),
        .rd_data (high_rd)
    );

    // decode stage holding one low byte while its ram reads land
    logic [BYTE_W-1:0] b_byte_reg;
    logic [ADDR_W-1:0] b_j_reg;
    logic [LEAD_W-1:0] b_lead_reg;
    logic              b_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_tready) begin
            b_valid_reg <= low_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (low_xfer) begin
            b_byte_reg <= in_byte;
            b_j_reg    <= j_addr;
            b_lead_reg <= lead_reg;
            b_last_reg <= j_last;
        end
    end

    // lead stores, read on accept and written as the sample leaves decode
    logic [SAMP_W-1:0] one_rd, two_rd, three_rd;
    logic [SAMP_W-1:0] rebuilt;
    logic              wr_one, wr_two, wr_three;

    assign wr_one   = b_adv && (b_lead_reg == LEAD_I);
    assign wr_two   = b_adv && (b_lead_reg == LEAD_II);
    assign wr_three = b_adv && (b_lead_reg == LEAD_III);

    ecgd_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_SAMPLES)) u_lead_one (
        .aclk    (aclk),
        .wr_en   (wr_one),
        .wr_addr (b_j_reg),
        .wr_data (rebuilt),
        .rd_en   (low_xfer),
        .rd_addr (j_addr),
        .rd_data (one_rd)
    );

    ecgd_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_SAMPLES)) u_lead_two (
        .aclk    (aclk),
        .wr_en   (wr_two),
        .wr_addr (b_j_reg),
        .wr_data (rebuilt),
        .rd_en   (low_xfer),
        .rd_addr (j_addr),
        .rd_data (two_rd)
    );

    ecgd_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_SAMPLES)) u_lead_three (
        .aclk    (aclk),
        .wr_en   (wr_three),
        .wr_addr (b_j_reg),
        .wr_data (rebuilt),
        .rd_en   (low_xfer),
        .rd_addr (j_addr),
        .rd_data (three_rd)
    );

    // delta history
    logic [SAMP_W-1:0] older_reg, older_next;
    logic [SAMP_W-1:0] newer_reg, newer_next;
    logic [SAMP_W-1:0] carried_reg, carried_next;
    logic [SAMP_W-1:0] raw;
    logic [SAMP_W-1:0] dec;

    always_comb begin
        raw          = {high_rd, b_byte_reg};
        older_next   = older_reg;
        newer_next   = newer_reg;
        carried_next = carried_reg;
        if (b_j_reg == ADDR_W'(0)) begin
            dec = raw;
        end else if (b_j_reg == ADDR_W'(1)) begin
            dec = raw;
        end else begin
            dec = {newer_reg[SAMP_W-2:0], 1'b0} - older_reg - carried_reg;
        end
        if (b_adv) begin
            if (b_j_reg == ADDR_W'(0)) begin
                older_next = raw;
            end else if (b_j_reg == ADDR_W'(1)) begin
                newer_next = raw;
            end else begin
                carried_next = raw - LAST_BIAS;
                older_next   = newer_reg;
                newer_next   = dec;
            end
        end
        // a chunk mark comes later in stream order than the sample leaving decode
        if (s_xfer && in_chunk) begin
            carried_next = in_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg   <= '0;
            newer_reg   <= '0;
            carried_reg <= '0;
        end else begin
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            carried_reg <= carried_next;
        end
    end

    // halving of a 17 bit sum, rounded toward zero
    function automatic logic [SAMP_W-1:0] half_sum(input logic [SAMP_W:0] s);
        logic [SAMP_W:0] t;
        t = s + {{SAMP_W{1'b0}}, s[SAMP_W]};
        return t[SAMP_W:1];
    endfunction

    // limb lead rebuild from stored leads
    logic [SAMP_W:0] sum_ab, dif_ac, sum_bc;

    always_comb begin
        sum_ab = {one_rd[SAMP_W-1], one_rd} + {two_rd[SAMP_W-1], two_rd};
        dif_ac = {one_rd[SAMP_W-1], one_rd} - {three_rd[SAMP_W-1], three_rd};
        sum_bc = {two_rd[SAMP_W-1], two_rd} + {three_rd[SAMP_W-1], three_rd};
        case (b_lead_reg)
            LEAD_III: rebuilt = two_rd - one_rd - dec;
            LEAD_AVR: rebuilt = SAMP_W'(0) - half_sum(sum_ab) - dec;
            LEAD_AVL: rebuilt = half_sum(dif_ac) - dec;
            LEAD_AVF: rebuilt = half_sum(sum_bc) - dec;
            default:  rebuilt = dec;
        endcase
    end

    // output register
    logic [SAMP_W-1:0] m_sample_reg;
    logic [SNUM_W-1:0] m_snum_reg;
    logic [LEAD_W-1:0] m_lead_reg;
    logic              m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_sample_reg <= rebuilt;
            m_snum_reg   <= SNUM_W'(b_j_reg);
            m_lead_reg   <= b_lead_reg;
            m_last_reg   <= b_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_snum_reg, m_sample_reg};
    assign m_tuser  = m_lead_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `ASSERT_ALWAYS(a_lead_range, 32'(lead_reg) < NUM_LEADS, "lead count out of range")
    `ASSERT_CLK(a_last_resets_pos, (low_xfer && j_last) |=> (pos_reg == '0),
                "byte position not cleared after last low byte")
    `ASSERT_CLK(a_decode_hold, (b_valid_reg && !out_free) |=> (b_valid_reg && $stable(b_j_reg)),
                "decode stage lost its sample while stalled")

endmodule

// ----- verif/ecgd_sample_checker.sv -----
`timescale 1ns / 100ps
// sample predictor and output stream checker for the lead delta decoder
module ecgd_sample_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ecgd_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [23:0]                s_tdata,     // delta_byte[7:0], start_value[23:8]
    input  logic [0:0]                 s_tuser,     // chunk_start
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [31:0]                m_tdata,     // sample_value[15:0], sample_number[28:16]
    input  logic [3:0]                 m_tuser,     // lead_number
    input  logic                       m_tlast,     // lead_done
    output int                         pending,
    output int                         fail_count
);
    import ecgd_pkg::*;

    typedef struct packed {
        logic [SAMP_W-1:0] value;
        logic [LEAD_W-1:0] lead;
        logic [SNUM_W-1:0] index;
        logic              done;
    } sample_t;

    logic [BYTE_W-1:0] high_bytes   [MAX_SAMPLES];
    logic [SAMP_W-1:0] lead_i_mem   [MAX_SAMPLES];
    logic [SAMP_W-1:0] lead_ii_mem  [MAX_SAMPLES];
    logic [SAMP_W-1:0] lead_iii_mem [MAX_SAMPLES];
    logic [SAMP_W-1:0] older, newer, carry;
    logic [CFG_W-1:0]  length_reg;
    logic [LEAD_W-1:0] lead_idx;
    int unsigned       pos;
    sample_t           due_samples[$];
    int                errors;

    // limb leads from i, ii and the stored iii; halving truncates toward zero
    function automatic logic [SAMP_W-1:0] rebuild_lead(int unsigned j, logic [SAMP_W-1:0] v);
        int a, b, c, x, r;
        a = int'($signed(lead_i_mem[j]));
        b = int'($signed(lead_ii_mem[j]));
        c = int'($signed(lead_iii_mem[j]));
        x = int'($signed(v));
        case (lead_idx)
            LEAD_I: begin
                lead_i_mem[j] = v;
                return v;
            end
            LEAD_II: begin
                lead_ii_mem[j] = v;
                return v;
            end
            LEAD_III: begin
                r = b - a - x;
                lead_iii_mem[j] = r[SAMP_W-1:0];
                return r[SAMP_W-1:0];
            end
            LEAD_AVR: r = -((a + b) / 2) - x;
            LEAD_AVL: r = ((a - c) / 2) - x;
            LEAD_AVF: r = ((b + c) / 2) - x;
            default: return v;
        endcase
        return r[SAMP_W-1:0];
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] data_byte, input logic chunk_first,
                               input logic [SAMP_W-1:0] start_val);
        int unsigned n, j;
        logic [SAMP_W-1:0] raw, v;
        sample_t s;
        n = 32'(length_reg);
        if (n == 0) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        if (chunk_first) begin
            pos = 0;
            carry = start_val;
        end
        // a shrunk length can leave the position past the chunk
        if (pos >= 2 * n) pos = 0;
        if (pos < n) begin
            high_bytes[pos] = data_byte;
            pos++;
            return;
        end
        j = pos - n;
        raw = {high_bytes[j], data_byte};
        if (j == 0) begin
            older = raw;
            v = raw;
        end else if (j == 1) begin
            newer = raw;
            v = raw;
        end else begin
            v = (newer << 1) - older - carry;
            carry = raw - LAST_BIAS;
            older = newer;
            newer = v;
        end
        s.value = rebuild_lead(j, v);
        s.lead  = lead_idx;
        s.index = j[SNUM_W-1:0];
        s.done  = (j == n - 1);
        due_samples.push_back(s);
        if (j == n - 1) begin
            pos = 0;
            lead_idx = (lead_idx == NUM_LEADS - 1) ? '0 : lead_idx + 1'b1;
        end else begin
            pos++;
        end
    endtask

    always @(posedge aclk) begin
        sample_t got, want;
        if (!aresetn) begin
            length_reg = CFG_RESET;
            older = '0;
            newer = '0;
            carry = '0;
            pos = 0;
            lead_idx = '0;
            due_samples.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[15:0];
                got.lead  = m_tuser;
                got.index = m_tdata[28:16];
                got.done  = m_tlast;
                if (due_samples.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected sample: value %0d lead %0d index %0d done %0b",
                                 $signed(got.value), got.lead, got.index, got.done);
                end else begin
                    want = due_samples.pop_front();
                    if (got.value !== want.value || got.lead !== want.lead ||
                        got.index !== want.index || got.done !== want.done) begin
                        errors++;
                        if (errors <= 10)
                            $display("sample mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     $signed(want.value), want.lead, want.index, want.done,
                                     $signed(got.value), got.lead, got.index, got.done);
                    end
                end
            end
            if (cfg_wr_en) length_reg = cfg_wr_data;
            if (s_tvalid && s_tready) decode_byte(s_tdata[7:0], s_tuser[0], s_tdata[23:8]);
        end
        pending <= due_samples.size();
        fail_count <= errors;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// top of the lead delta decoder testbench: clock, reset, byte stimulus and verdict
module tb_top;
    import ecgd_pkg::*;

    // random bytes after the directed part; idling stops near the end
    localparam int RANDOM_BYTES = 1600;
    localparam int CALM_AFTER   = 1350;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    wire              s_tready;
    logic [23:0]      s_tdata     = '0;     // delta_byte[7:0], start_value[23:8]
    logic [0:0]       s_tuser     = '0;     // chunk_start
    wire              m_tvalid;
    logic             m_tready    = 1'b0;
    wire  [31:0]      m_tdata;              // sample_value[15:0], sample_number[28:16]
    wire  [3:0]       m_tuser;              // lead_number
    wire              m_tlast;              // lead_done
    int               pending;
    int               fail_count;

    // where the stream stands in the block, so length changes never expose unwritten ram
    int unsigned cur_len   = 0;
    int unsigned chunk_pos = 0;
    int unsigned lead_pos  = 0;
    int          random_sent = 0;
    bit          counting = 1'b0;
    bit          calm     = 1'b0;
    // quiet stretches with no idling on either side
    bit          quiet    = 1'b0;
    int          stall_left = 0;

    ecg_lead_delta_decoder_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    ecgd_sample_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side stalls in bursts of random length, none in calm or quiet stretches
    always @(posedge aclk) begin
        if ($urandom_range(0, 149) == 0) quiet <= ~quiet;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int unsigned eff_len(logic [CFG_W-1:0] val);
        if (val == 0) return 1;
        if (val > MAX_SAMPLES) return MAX_SAMPLES;
        return 32'(val);
    endfunction

    // leads i to iii fill the stores, so growth waits for a new set of leads at a chunk
    // boundary; leads past avf touch no store, so they may shrink in mid chunk
    function automatic bit length_ok(logic [CFG_W-1:0] val);
        bit fresh_set;
        fresh_set = (lead_pos == LEAD_I) || (lead_pos > LEAD_AVF);
        if (eff_len(val) > cur_len) return chunk_pos == 0 && fresh_set;
        return chunk_pos == 0 || lead_pos > LEAD_AVF;
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 15);
        // zero reads as one; one and two only pass raw samples through
        if (r < 3) return CFG_W'(r);
        if (r < 11) return CFG_W'($urandom_range(3, 8));
        if (r < 14) return CFG_W'($urandom_range(9, 24));
        return CFG_W'($urandom_range(25, 60));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SAMP_W-1:0] rand_start();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return SAMP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // one byte transfer, with an optional gap in front
    task automatic send_byte(input logic [BYTE_W-1:0] data_byte, input logic mark,
                             input logic [SAMP_W-1:0] start_val);
        if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {start_val, data_byte};
        s_tuser  <= mark;
        do @(posedge aclk); while (!s_tready);
        if (mark) chunk_pos = 0;
        if (chunk_pos >= 2 * cur_len) chunk_pos = 0;
        if (chunk_pos < cur_len || chunk_pos - cur_len != cur_len - 1) begin
            chunk_pos++;
        end else begin
            chunk_pos = 0;
            lead_pos = (lead_pos == NUM_LEADS - 1) ? 0 : lead_pos + 1;
        end
        if (counting) random_sent++;
        calm = (random_sent >= CALM_AFTER);
    endtask

    task automatic send_chunk(input logic mark, input int unsigned count);
        send_byte(rand_byte(), mark, rand_start());
        repeat (count - 1) send_byte(rand_byte(), 1'b0, rand_start());
    endtask

    // length is written only once the block has drained
    task automatic set_length(input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_len = eff_len(val);
    endtask

    initial begin
        int n_chunks;
        int kind;
        logic [CFG_W-1:0] pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        cur_len = eff_len(CFG_RESET);

        // directed: chunks of length three with byte and start value extremes
        set_length(CFG_W'(3));
        send_byte(8'hFF, 1'b1, 16'h8000);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'h80, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'h7F, 1'b0, 16'h0000);
        send_byte(8'h00, 1'b1, 16'h7FFF);
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'h7F, 1'b0, 16'h0000);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'h80, 1'b0, 16'h0000);
        // lead iii with no chunk mark, cut off by a restart with a mark
        send_byte(8'h5A, 1'b0, 16'hFFFF);
        send_byte(8'hA5, 1'b0, 16'h0000);
        send_byte(8'hC3, 1'b0, 16'h0000);
        send_byte(8'h3C, 1'b0, 16'h0000);
        send_byte(8'h12, 1'b1, 16'h1234);
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'h80, 1'b0, 16'h0000);
        send_byte(8'h7F, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'h0000);
        // zero length behaves as one sample per lead
        set_length(CFG_W'(0));
        send_byte(8'hAB, 1'b1, 16'hFFFE);
        send_byte(8'hCD, 1'b0, 16'h0000);

        // largest length written as all ones, a short run of high bytes, then a
        // shrink in mid chunk on a lead that touches no store
        while (!(lead_pos == LEAD_I || lead_pos > LEAD_AVF)) send_chunk(1'b1, 2 * cur_len);
        set_length('1);
        send_chunk(1'b1, 40);
        set_length(CFG_W'(5));

        // random part: mostly whole chunks, some unmarked, cut short or loose bytes
        counting = 1'b1;
        while (random_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 2) != 0) begin
                pick = pick_length();
                if (length_ok(pick)) set_length(pick);
            end
            n_chunks = $urandom_range(1, 4);
            repeat (n_chunks) begin
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    send_chunk(1'b1, 2 * cur_len);
                else if (kind < 16)
                    send_chunk(1'b0, 2 * cur_len);
                else if (kind < 18)
                    send_chunk(1'b1, $urandom_range(1, 2 * cur_len));
                else
                    repeat ($urandom_range(1, 8))
                        send_byte(rand_byte(), $urandom_range(0, 7) == 0, rand_start());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("ecg_lead_delta_decoder_unit verification clean");
        else
            $display("ecg_lead_delta_decoder_unit verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest passing run
    initial begin
        #25_000_000;
        $display("ecg_lead_delta_decoder_unit verification failed");
        $finish;
    end

endmodule
